>>> src/bitmap_page_frame_allocator_top_defines.svh
// Assertion helpers for the page frame allocator.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bpfa_pkg.sv
`timescale 1ns / 1ps

package bpfa_pkg;

    // Default geometry.
    localparam int MAX_PAGES_DEF  = 65536;
    localparam int PAGE_BYTES_DEF = 4096;

    // Bitmap word: 64 pages per memory entry.
    localparam int WORD_BITS  = 64;
    localparam int WORD_SHIFT = 6;

    // Width used for page numbers computed from byte addresses.
    localparam int PAGE_W = 50;

    // Reset value of the minimum physical address register.
    localparam logic [47:0] MIN_PHYS_RESET = 48'd1048576;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PAGES_IN_USE  = 2'd0;
    localparam logic [1:0] CFG_STORAGE_FIRST = 2'd1;
    localparam logic [1:0] CFG_STORAGE_END   = 2'd2;
    localparam logic [1:0] CFG_MIN_PHYS      = 2'd3;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_MISALIGNED  = 3'd1,
        ST_UNMANAGED   = 3'd2,
        ST_DOUBLE_FREE = 3'd3,
        ST_EXHAUSTED   = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [47:0] address;
        logic [48:0] end_address;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [27:0] page_address;
        logic [16:0] pages_added;
        logic        page_is_free;
        logic [16:0] free_count;
        logic [16:0] managed_count;
    } out_item_t;

    // Offset of page v inside the word starting at page base, clamped to 0..64.
    function automatic logic [6:0] clip_off(input logic [PAGE_W-1:0] v,
                                            input logic [PAGE_W-1:0] base);
        logic [PAGE_W-1:0] diff;
        diff = v - base;
        if (v <= base)
            return 7'd0;
        else if (diff >= PAGE_W'(WORD_BITS))
            return 7'(WORD_BITS);
        else
            return diff[6:0];
    endfunction

    // Bits lo up to but not including hi are set.
    function automatic logic [WORD_BITS-1:0] range_mask(input logic [6:0] lo,
                                                        input logic [6:0] hi);
        logic [WORD_BITS-1:0] m;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            m[b] = (7'(b) >= lo) && (7'(b) < hi);
        end
        return m;
    endfunction

    // Index of the lowest set bit; zero when none is set.
    function automatic logic [WORD_SHIFT-1:0] lowest_bit(input logic [WORD_BITS-1:0] m);
        logic [WORD_SHIFT-1:0] idx;
        idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (m[b])
                idx = WORD_SHIFT'(b);
        end
        return idx;
    endfunction

    function automatic logic [6:0] popcount(input logic [WORD_BITS-1:0] m);
        logic [6:0] c;
        c = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            c = c + 7'(m[b]);
        end
        return c;
    endfunction

endpackage

>>> src/bitmap_page_frame_allocator_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// in        input      in_valid / in_stall      in_item   (bpfa_pkg::in_item_t)
// out       output     out_valid / out_stall    out_item  (bpfa_pkg::out_item_t)
// cfg       input      cfg_we                   cfg_index, cfg_data
//
// After reset a clearing pass writes one bitmap word per cycle and no item is accepted
// meanwhile. Each item is accepted in the idle state, passes a setup state and ends in a final
// state that loads the output register. Add range sets up, then reads, modifies and counts
// each 64-page word; allocate reads and checks each word scanned, after remainder steps when
// the cursor lies beyond the pages in use; free and query read one word unless the address
// alone decides them. A result waiting under out_stall holds the next item in its final state.

`include "bitmap_page_frame_allocator_top_defines.svh"

module bitmap_page_frame_allocator_top #(
    parameter int MAX_PAGES  = bpfa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = bpfa_pkg::PAGE_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bpfa_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output bpfa_pkg::out_item_t out_item,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [47:0]         cfg_data
);

    localparam int W        = bpfa_pkg::WORD_BITS;
    localparam int WS       = bpfa_pkg::WORD_SHIFT;
    localparam int PW       = bpfa_pkg::PAGE_W;
    localparam int PB_SHIFT = $clog2(PAGE_BYTES);
    localparam int WORDS    = (MAX_PAGES + W - 1) / W;
    localparam int WAW      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNTW     = $clog2(MAX_PAGES + 1);
    localparam int CURW     = $clog2(MAX_PAGES);
    localparam int DCW      = $clog2(CURW + 1);
    localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_SETUP   = 13'b0000000000100,
        S_ADD_SET = 13'b0000000001000,
        S_ADD_RD  = 13'b0000000010000,
        S_ADD_MOD = 13'b0000000100000,
        S_ADD_CNT = 13'b0000001000000,
        S_AL_MOD  = 13'b0000010000000,
        S_AL_RD   = 13'b0000100000000,
        S_AL_CHK  = 13'b0001000000000,
        S_PG_RD   = 13'b0010000000000,
        S_PG_CHK  = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } state_t;

    // Control state.
    state_t              state_reg, state_next;
    logic [WAW-1:0]      word_reg, word_next;
    logic                out_valid_reg, out_valid_next;
    logic [CNTW-1:0]     free_cnt_reg, free_cnt_next;
    logic [CNTW-1:0]     managed_cnt_reg, managed_cnt_next;
    logic [CURW-1:0]     cursor_reg, cursor_next;

    // Configuration registers.
    logic [16:0]         cfg_pages_reg;
    logic [36:0]         cfg_sfirst_reg;
    logic [36:0]         cfg_send_reg;
    logic [47:0]         cfg_minp_reg;

    // Working registers of the current item.
    bpfa_pkg::in_item_t  item_reg, item_next;
    logic [WAW-1:0]      endw_reg, endw_next;
    logic [PW-1:0]       first_reg, first_next;
    logic [PW-1:0]       last_reg, last_next;
    logic [PW-1:0]       lo_reg, lo_next;
    logic [PW-1:0]       hi_reg, hi_next;
    logic [CURW-1:0]     start_reg, start_next;
    logic                phase_reg, phase_next;
    logic [W-1:0]        rng_mask_reg, rng_mask_next;
    logic [W-1:0]        win_mask_reg, win_mask_next;
    logic [W-1:0]        new_mask_reg, new_mask_next;
    logic [CNTW-1:0]     added_reg, added_next;
    logic [CNTW-1:0]     div_rem_reg, div_rem_next;
    logic [CURW-1:0]     div_num_reg, div_num_next;
    logic [DCW-1:0]      div_cnt_reg, div_cnt_next;
    logic [2:0]          status_reg, status_next;
    logic [27:0]         paddr_reg, paddr_next;
    logic                is_free_reg, is_free_next;
    bpfa_pkg::out_item_t out_item_reg, out_item_next;

    // Bitmap memory: each word holds {managed bits, free bits}.
    logic [2*W-1:0]      mem_q [WORDS];
    logic [2*W-1:0]      rd_data_reg;
    logic                mem_we;
    logic [2*W-1:0]      mem_wdata;

    // Derived values.
    logic [CNTW-1:0]     n_pages;
    logic [PW-1:0]       n_wide;
    logic [PW-1:0]       word_base;
    logic [PW-1:0]       item_page;
    logic [47:0]         add_base;
    logic [PW-1:0]       add_last;
    logic [W-1:0]        rd_managed;
    logic [W-1:0]        rd_free;
    logic [W-1:0]        cand;
    logic [WS-1:0]       cand_idx;
    logic [PW-1:0]       found_page;
    logic [WS-1:0]       bit_idx;
    logic [CNTW:0]       div_trial;
    logic [CNTW:0]       div_rest;
    logic [CNTW-1:0]     add_sum;

    // Pages in use, clamped to the bitmap size.
    always_comb
    begin
        n_pages = (32'(cfg_pages_reg) < MAX_PAGES) ? CNTW'(cfg_pages_reg)
                                                    : CNTW'(MAX_PAGES);
    end

    assign n_wide     = PW'(n_pages);
    assign word_base  = PW'(word_reg) << WS;
    assign item_page  = PW'(item_reg.address >> PB_SHIFT);
    assign bit_idx    = item_page[WS-1:0];
    assign rd_managed = rd_data_reg[2*W-1:W];
    assign rd_free    = rd_data_reg[W-1:0];
    assign cand       = rd_free & rng_mask_reg;
    assign cand_idx   = bpfa_pkg::lowest_bit(cand);
    assign found_page = word_base + PW'(cand_idx);
    assign add_sum    = added_reg + CNTW'(bpfa_pkg::popcount(new_mask_reg));
    assign add_base   = (item_reg.address < cfg_minp_reg) ? cfg_minp_reg : item_reg.address;
    assign add_last   = PW'(item_reg.end_address) >> PB_SHIFT;

    // One restoring remainder step for reducing the cursor modulo the pages in use.
    always_comb
    begin
        div_trial = {div_rem_reg, div_num_reg[CURW-1]};
        div_rest  = (div_trial >= {1'b0, n_pages}) ? div_trial - {1'b0, n_pages}
                                                   : div_trial;
    end

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        word_next        = word_reg;
        out_valid_next   = out_valid_reg && out_stall;
        free_cnt_next    = free_cnt_reg;
        managed_cnt_next = managed_cnt_reg;
        cursor_next      = cursor_reg;
        item_next        = item_reg;
        endw_next        = endw_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        start_next       = start_reg;
        phase_next       = phase_reg;
        rng_mask_next    = rng_mask_reg;
        win_mask_next    = win_mask_reg;
        new_mask_next    = new_mask_reg;
        added_next       = added_reg;
        div_rem_next     = div_rem_reg;
        div_num_next     = div_num_reg;
        div_cnt_next     = div_cnt_reg;
        status_next      = status_reg;
        paddr_next       = paddr_reg;
        is_free_next     = is_free_reg;
        out_item_next    = out_item_reg;
        mem_we           = 1'b0;
        mem_wdata        = rd_data_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (word_reg == LAST_WORD)
                begin
                    word_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next    = in_item;
                    status_next  = bpfa_pkg::ST_OK;
                    paddr_next   = '0;
                    added_next   = '0;
                    is_free_next = 1'b0;
                    state_next   = S_SETUP;
                end
            end

            S_SETUP:
            begin
                case (item_reg.operation)
                    bpfa_pkg::OP_ADD:
                    begin
                        first_next = (PW'(add_base) + PW'(PAGE_BYTES - 1)) >> PB_SHIFT;
                        last_next  = (add_last > n_wide) ? n_wide : add_last;
                        state_next = S_ADD_SET;
                    end
                    bpfa_pkg::OP_ALLOC:
                    begin
                        if (free_cnt_reg == '0 || n_pages == '0)
                        begin
                            status_next = bpfa_pkg::ST_EXHAUSTED;
                            state_next  = S_DONE;
                        end
                        else if (PW'(cursor_reg) >= n_wide)
                        begin
                            div_rem_next = '0;
                            div_num_next = cursor_reg;
                            div_cnt_next = '0;
                            state_next   = S_AL_MOD;
                        end
                        else
                        begin
                            start_next = cursor_reg;
                            lo_next    = PW'(cursor_reg);
                            hi_next    = n_wide;
                            phase_next = 1'b0;
                            word_next  = WAW'(cursor_reg >> WS);
                            state_next = S_AL_RD;
                        end
                    end
                    bpfa_pkg::OP_FREE:
                    begin
                        if (item_reg.address[PB_SHIFT-1:0] != '0)
                        begin
                            status_next = bpfa_pkg::ST_MISALIGNED;
                            state_next  = S_DONE;
                        end
                        else if (item_page >= n_wide)
                        begin
                            status_next = bpfa_pkg::ST_UNMANAGED;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            word_next  = WAW'(item_page >> WS);
                            state_next = S_PG_RD;
                        end
                    end
                    default:
                    begin
                        // Query: pages beyond the pages in use are never free.
                        if (item_page >= n_wide)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            word_next  = WAW'(item_page >> WS);
                            state_next = S_PG_RD;
                        end
                    end
                endcase
            end

            S_ADD_SET:
            begin
                if (first_reg >= last_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    word_next  = WAW'(first_reg >> WS);
                    endw_next  = WAW'((last_reg - 1'b1) >> WS);
                    state_next = S_ADD_RD;
                end
            end

            S_ADD_RD:
            begin
                // Range and storage window masks for this word.
                rng_mask_next = bpfa_pkg::range_mask(
                    bpfa_pkg::clip_off(first_reg, word_base),
                    bpfa_pkg::clip_off(last_reg, word_base));
                win_mask_next = bpfa_pkg::range_mask(
                    bpfa_pkg::clip_off(PW'(cfg_sfirst_reg), word_base),
                    bpfa_pkg::clip_off(PW'(cfg_send_reg), word_base));
                state_next = S_ADD_MOD;
            end

            S_ADD_MOD:
            begin
                new_mask_next = rng_mask_reg & ~win_mask_reg & ~rd_managed;
                mem_we        = 1'b1;
                mem_wdata     = {rd_managed | new_mask_next, rd_free | new_mask_next};
                state_next    = S_ADD_CNT;
            end

            S_ADD_CNT:
            begin
                added_next = add_sum;
                if (word_reg == endw_reg)
                begin
                    free_cnt_next    = free_cnt_reg + add_sum;
                    managed_cnt_next = managed_cnt_reg + add_sum;
                    state_next       = S_DONE;
                end
                else
                begin
                    word_next  = word_reg + 1'b1;
                    state_next = S_ADD_RD;
                end
            end

            S_AL_MOD:
            begin
                div_rem_next = CNTW'(div_rest);
                div_num_next = div_num_reg << 1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCW'(CURW - 1))
                begin
                    start_next = CURW'(div_rest);
                    lo_next    = PW'(div_rest);
                    hi_next    = n_wide;
                    phase_next = 1'b0;
                    word_next  = WAW'(div_rest >> WS);
                    state_next = S_AL_RD;
                end
            end

            S_AL_RD:
            begin
                rng_mask_next = bpfa_pkg::range_mask(
                    bpfa_pkg::clip_off(lo_reg, word_base),
                    bpfa_pkg::clip_off(hi_reg, word_base));
                state_next = S_AL_CHK;
            end

            S_AL_CHK:
            begin
                if (cand != '0)
                begin
                    mem_we        = 1'b1;
                    mem_wdata     = {rd_managed, rd_free & ~(W'(1) << cand_idx)};
                    free_cnt_next = free_cnt_reg - 1'b1;
                    cursor_next   = (found_page + 1'b1 == n_wide) ? '0
                                                                  : CURW'(found_page + 1'b1);
                    paddr_next    = 28'(found_page << PB_SHIFT);
                    state_next    = S_DONE;
                end
                else if (word_base + PW'(W) < hi_reg)
                begin
                    word_next  = word_reg + 1'b1;
                    state_next = S_AL_RD;
                end
                else if (!phase_reg && start_reg != '0)
                begin
                    // Wrap around to the pages below the starting point.
                    phase_next = 1'b1;
                    lo_next    = '0;
                    hi_next    = PW'(start_reg);
                    word_next  = '0;
                    state_next = S_AL_RD;
                end
                else
                begin
                    status_next = bpfa_pkg::ST_EXHAUSTED;
                    state_next  = S_DONE;
                end
            end

            S_PG_RD:
            begin
                state_next = S_PG_CHK;
            end

            S_PG_CHK:
            begin
                if (item_reg.operation == bpfa_pkg::OP_QUERY)
                begin
                    is_free_next = rd_free[bit_idx];
                end
                else if (!rd_managed[bit_idx])
                begin
                    status_next = bpfa_pkg::ST_UNMANAGED;
                end
                else if (rd_free[bit_idx])
                begin
                    status_next = bpfa_pkg::ST_DOUBLE_FREE;
                end
                else
                begin
                    mem_we        = 1'b1;
                    mem_wdata     = {rd_managed, rd_free | (W'(1) << bit_idx)};
                    free_cnt_next = free_cnt_reg + 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.status        = status_reg;
                    out_item_next.page_address  = paddr_reg;
                    out_item_next.pages_added   = 17'(added_reg);
                    out_item_next.page_is_free  = is_free_reg;
                    out_item_next.free_count    = 17'(free_cnt_reg);
                    out_item_next.managed_count = 17'(managed_cnt_reg);
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            word_reg        <= '0;
            out_valid_reg   <= 1'b0;
            free_cnt_reg    <= '0;
            managed_cnt_reg <= '0;
            cursor_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            word_reg        <= word_next;
            out_valid_reg   <= out_valid_next;
            free_cnt_reg    <= free_cnt_next;
            managed_cnt_reg <= managed_cnt_next;
            cursor_reg      <= cursor_next;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_pages_reg  <= '0;
            cfg_sfirst_reg <= '0;
            cfg_send_reg   <= '0;
            cfg_minp_reg   <= bpfa_pkg::MIN_PHYS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bpfa_pkg::CFG_PAGES_IN_USE:  cfg_pages_reg  <= cfg_data[16:0];
                bpfa_pkg::CFG_STORAGE_FIRST: cfg_sfirst_reg <= cfg_data[36:0];
                bpfa_pkg::CFG_STORAGE_END:   cfg_send_reg   <= cfg_data[36:0];
                default:                     cfg_minp_reg   <= cfg_data;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        endw_reg     <= endw_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        start_reg    <= start_next;
        phase_reg    <= phase_next;
        rng_mask_reg <= rng_mask_next;
        win_mask_reg <= win_mask_next;
        new_mask_reg <= new_mask_next;
        added_reg    <= added_next;
        div_rem_reg  <= div_rem_next;
        div_num_reg  <= div_num_next;
        div_cnt_reg  <= div_cnt_next;
        status_reg   <= status_next;
        paddr_reg    <= paddr_next;
        is_free_reg  <= is_free_next;
        out_item_reg <= out_item_next;
    end

    // Bitmap memory with a registered read of the current word.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_q[word_reg] <= mem_wdata;
        rd_data_reg <= mem_q[word_reg];
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `BPFA_ASSERT_NOW(a_free_cnt, 1'b1, free_cnt_reg <= managed_cnt_reg, "free count too high")
    `BPFA_ASSERT_NEXT(a_accept, in_valid && !in_stall, state_reg == S_SETUP, "item not started")
    `BPFA_ASSERT_NEXT(a_load, state_reg == S_DONE && !out_valid_reg, out_valid_reg, "no result")

endmodule

>>> test/bpfa_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts each result of the
// page frame allocator and compares it with what the block returns.
module bpfa_checker
    import bpfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  in_item_t   in_item,
    input  logic       out_valid,
    input  logic       out_stall,
    input  out_item_t  out_item,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [47:0] cfg_data,
    output int         errors,
    output int         pending
);

    localparam int NPAGES = 65536;

    // Shadow copy of the registers and of the allocator state.
    logic [16:0] pages_reg;
    logic [36:0] store_first;
    logic [36:0] store_end;
    logic [47:0] min_phys;

    bit          used_bit [NPAGES];
    bit          managed_bit [NPAGES];
    logic [63:0] cursor;
    logic [31:0] free_total;
    logic [31:0] managed_total;

    out_item_t   pending_results[$];

    // Apply one item to the shadow state and return the result it causes.
    function automatic out_item_t allocator_result(in_item_t it);
        out_item_t   r;
        logic [63:0] addr;
        logic [63:0] lim;
        logic [63:0] base;
        logic [63:0] first;
        logic [63:0] last;
        logic [63:0] pg;
        logic [63:0] k;
        logic [31:0] added;
        bit          found;
        r = '0;
        added = 0;
        found = 0;
        addr = 64'(it.address);
        lim = (pages_reg < NPAGES) ? 64'(pages_reg) : 64'(NPAGES);
        case (op_t'(it.operation))
            OP_ADD:
            begin
                base = (addr < 64'(min_phys)) ? 64'(min_phys) : addr;
                first = (base + 64'd4095) / 64'd4096;
                last = 64'(it.end_address) / 64'd4096;
                if (last > lim)
                    last = lim;
                for (pg = first; pg < last; pg++)
                begin
                    if (!managed_bit[pg[15:0]] &&
                        !(pg >= 64'(store_first) && pg < 64'(store_end)))
                    begin
                        managed_bit[pg[15:0]] = 1;
                        used_bit[pg[15:0]] = 0;
                        added++;
                    end
                end
                managed_total += added;
                free_total += added;
                r.pages_added = added[16:0];
            end
            OP_ALLOC:
            begin
                if (free_total != 0 && lim != 0)
                begin
                    for (k = 0; k < lim && !found; k++)
                    begin
                        pg = (cursor + k) % lim;
                        if (managed_bit[pg[15:0]] && !used_bit[pg[15:0]])
                        begin
                            used_bit[pg[15:0]] = 1;
                            free_total--;
                            cursor = (pg + 1) % lim;
                            r.page_address = 28'(pg * 64'd4096);
                            found = 1;
                        end
                    end
                end
                if (!found)
                    r.status = ST_EXHAUSTED;
            end
            OP_FREE:
            begin
                pg = addr / 64'd4096;
                if (addr[11:0] != 0)
                    r.status = ST_MISALIGNED;
                else if (pg >= lim || !managed_bit[pg[15:0]])
                    r.status = ST_UNMANAGED;
                else if (!used_bit[pg[15:0]])
                    r.status = ST_DOUBLE_FREE;
                else
                begin
                    used_bit[pg[15:0]] = 0;
                    free_total++;
                end
            end
            default:
            begin
                pg = addr / 64'd4096;
                r.page_is_free = (pg < lim) && managed_bit[pg[15:0]] && !used_bit[pg[15:0]];
            end
        endcase
        r.free_count = free_total[16:0];
        r.managed_count = managed_total[16:0];
        return r;
    endfunction

    // Track registers, predict accepted items and check accepted results.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            pages_reg = '0;
            store_first = '0;
            store_end = '0;
            min_phys = MIN_PHYS_RESET;
            for (int p = 0; p < NPAGES; p++)
            begin
                used_bit[p] = 1;
                managed_bit[p] = 0;
            end
            cursor = 0;
            free_total = 0;
            managed_total = 0;
            pending_results.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PAGES_IN_USE:  pages_reg = cfg_data[16:0];
                    CFG_STORAGE_FIRST: store_first = cfg_data[36:0];
                    CFG_STORAGE_END:   store_end = cfg_data[36:0];
                    default:           min_phys = cfg_data;
                endcase
            end
            // The result is checked before this edge's item is predicted.
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result item with no expected item waiting");
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_item.status !== want.status)
                    begin
                        $error("status expected %0h actual %0h", want.status, out_item.status);
                        errors++;
                    end
                    if (out_item.page_address !== want.page_address)
                    begin
                        $error("page_address expected %0h actual %0h",
                               want.page_address, out_item.page_address);
                        errors++;
                    end
                    if (out_item.pages_added !== want.pages_added)
                    begin
                        $error("pages_added expected %0h actual %0h",
                               want.pages_added, out_item.pages_added);
                        errors++;
                    end
                    if (out_item.page_is_free !== want.page_is_free)
                    begin
                        $error("page_is_free expected %0h actual %0h",
                               want.page_is_free, out_item.page_is_free);
                        errors++;
                    end
                    if (out_item.free_count !== want.free_count)
                    begin
                        $error("free_count expected %0h actual %0h",
                               want.free_count, out_item.free_count);
                        errors++;
                    end
                    if (out_item.managed_count !== want.managed_count)
                    begin
                        $error("managed_count expected %0h actual %0h",
                               want.managed_count, out_item.managed_count);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_results.push_back(allocator_result(in_item));
        end
        pending = pending_results.size();
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bpfa_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_item;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_item;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [47:0] cfg_data;
    int         errors;
    int         pending;

    // Stimulus-side view of the configuration, used to aim addresses.
    int         span_pages;
    bit         calm;
    bit         long_hold_req;

    bitmap_page_frame_allocator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bpfa_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // Clock with a 4 ns period.
    initial
    begin
        clk = 0;
    end

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // Hard limit on the run time.
    initial
    begin
        #100_000_000;
        $display("status: fail");
        $finish;
    end

    // Mostly short gaps, sometimes long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Receiver side: random stalls, and one long hold-off when asked.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                out_stall = 1;
                hold_left--;
            end
            else
            begin
                hold_left = gap_len();
                out_stall = (hold_left > 0);
                if (hold_left > 0)
                    hold_left--;
            end
        end
    end

    // Offer one item after a random gap and wait until it is taken.
    task automatic send(input op_t op, input logic [47:0] a, input logic [48:0] e);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid = 0;
            repeat (g) @(negedge clk);
        end
        in_valid = 1;
        in_item.operation = op;
        in_item.address = a;
        in_item.end_address = e;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Stop offering items until every expected result has arrived.
    task automatic drain();
        in_valid = 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic configure(input logic [16:0] npg, input logic [36:0] sf,
                             input logic [36:0] se, input logic [47:0] mn);
        write_reg(CFG_PAGES_IN_USE, 48'(npg));
        write_reg(CFG_STORAGE_FIRST, 48'(sf));
        write_reg(CFG_STORAGE_END, 48'(se));
        write_reg(CFG_MIN_PHYS, mn);
        span_pages = (npg > 65536) ? 65536 : int'(npg);
    endtask

    // One random item aimed mostly at the pages in use.
    task automatic random_item();
        int          r;
        int          pg;
        int          len;
        logic [63:0] wide;
        logic [47:0] a;
        logic [48:0] e;
        op_t         op;
        r = $urandom_range(0, 99);
        op = (r < 15) ? OP_ADD : (r < 50) ? OP_ALLOC : (r < 85) ? OP_FREE : OP_QUERY;
        pg = $urandom_range(0, span_pages + 16);
        wide = {$urandom, $urandom};
        a = 48'(pg) << 12;
        if ($urandom_range(0, 99) < 8)
            a = wide[47:0];
        else if (op != OP_ADD && $urandom_range(0, 99) < 12)
            a[11:0] = 12'($urandom);
        else if (op == OP_ADD && $urandom_range(0, 99) < 30)
            a[11:0] = 12'($urandom);
        r = $urandom_range(0, 99);
        len = (r < 90) ? $urandom_range(0, 40) : $urandom_range(0, span_pages);
        e = (49'(pg) + 49'(len)) << 12;
        if ($urandom_range(0, 99) < 30)
            e[11:0] = 12'($urandom);
        if ($urandom_range(0, 99) < 3)
            e = 49'({$urandom, $urandom});
        send(op, a, e);
    endtask

    task automatic random_phase(input int count);
        for (int k = 0; k < count; k++)
            random_item();
        drain();
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        in_item = '0;
        cfg_we = 0;
        cfg_index = CFG_PAGES_IN_USE;
        cfg_data = '0;
        calm = 0;
        long_hold_req = 0;
        span_pages = 0;
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: alloc before anything is managed, then a small window.
        send(OP_ALLOC, 48'd0, 49'd0);
        drain();
        configure(17'd256, 37'd4, 37'd8, 48'd8192);
        send(OP_ADD, 48'd0, 49'h1_0000_0000_0000);
        send(OP_ADD, 48'd0, 49'h1_0000_0000_0000);
        send(OP_ADD, 48'h10_0000, 49'h8_0000);
        send(OP_ALLOC, 48'd0, 49'd0);
        send(OP_ALLOC, 48'd0, 49'd0);
        send(OP_FREE, 48'h2001, 49'd0);
        send(OP_FREE, 48'h12C000, 49'd0);
        send(OP_FREE, 48'h1000, 49'd0);
        send(OP_FREE, 48'h5000, 49'd0);
        send(OP_FREE, 48'hA000, 49'd0);
        send(OP_FREE, 48'h2000, 49'd0);
        send(OP_FREE, 48'h2000, 49'd0);
        send(OP_QUERY, 48'h2FFF, 49'd0);
        send(OP_QUERY, 48'h5000, 49'd0);
        send(OP_QUERY, 48'hFFFF_FFFF_FFFF, 49'd0);
        drain();

        // Eight pages, all free, then run out.
        configure(17'd8, 37'd0, 37'd0, 48'd0);
        send(OP_ADD, 48'd0, 49'h1_0000_0000_0000);
        for (int k = 0; k < 9; k++)
            send(OP_ALLOC, 48'd0, 49'd0);
        drain();

        // No pages in use at all.
        configure(17'd0, 37'h1F_FFFF_FFFF, 37'h1F_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send(OP_ALLOC, 48'd0, 49'd0);
        send(OP_QUERY, 48'd0, 49'd0);
        drain();

        // Random phases over several settings; state carries across them.
        configure(17'd300, 37'd20, 37'd30, 48'd0);
        random_phase(160);
        configure(17'd1000, 37'd100, 37'd90, 48'h10_0000);
        for (int k = 0; k < 60; k++)
            random_item();
        long_hold_req = 1;
        for (int k = 0; k < 100; k++)
            random_item();
        drain();
        configure(17'd150, 37'd0, 37'd150, 48'd4096);
        for (int k = 0; k < 80; k++)
            random_item();
        drain();
        for (int k = 0; k < 80; k++)
            random_item();
        drain();
        configure(17'd65536, 37'd1000, 37'd1100, 48'd0);
        random_phase(160);
        configure(17'd37, 37'h1F_FFFF_FFFF, 37'd0, 48'hFFFF_FFFF_FFFF);
        random_phase(120);
        calm = 1;
        configure(17'd2048, 37'd500, 37'd600, 48'h3F_F000);
        random_phase(160);
        calm = 0;
        configure(17'h1FFFF, 37'd0, 37'd0, 48'h123);
        random_phase(160);
        configure(17'd400, 37'd10, 37'd300, 48'd0);
        random_phase(160);

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
